@@ hdl/gated_least_squares_plane_fit_defines.svh @@
// assertion macros for the gated least-squares plane fit
// no dependencies; taken in by gated_least_squares_plane_fit, which checks its own logic
`ifndef GATED_LEAST_SQUARES_PLANE_FIT_DEFINES_SVH
`define GATED_LEAST_SQUARES_PLANE_FIT_DEFINES_SVH
`ifndef SYNTHESIS
`define GLSPF_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("glspf: implication check failed");
`define GLSPF_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("glspf: next-cycle check failed");
`else
`define GLSPF_ASSERT_IMP(name, clk, rst, ante, cons)
`define GLSPF_ASSERT_NXT(name, clk, rst, ante, cons)
`endif
`endif

@@ hdl/glspf_pkg.sv @@
// shared types, constants and the solver microprogram of the plane fit
// no dependencies; used by glspf_solver and gated_least_squares_plane_fit
package glspf_pkg;

   localparam int MAX_POINTS_DEF  = 65536;
   localparam int COORD_WIDTH_DEF = 24;

   localparam int PORT_W  = 24;
   localparam int RANGE_W = 23;
   localparam int OUT_W   = 32;
   localparam int COUNT_W = 17;
   localparam int SUM_W   = 64;
   localparam int LIN_W   = 48;
   localparam int WIDE_W  = 256;
   localparam int RADDR_W = 5;
   localparam int PC_W    = 6;

   localparam logic [RANGE_W-1:0] RANGE_LIMIT_RESET = 23'd327680;
   // 0.01 m in q8.16 is 655, squared
   localparam logic [LIN_W-1:0]   NEAR_SQ         = 48'd429025;
   localparam logic [COUNT_W-1:0] MIN_POINTS      = 17'd3;

   typedef struct packed {
      logic [COUNT_W-1:0] kept;
      logic [SUM_W-1:0]   sxx;
      logic [SUM_W-1:0]   sxy;
      logic [SUM_W-1:0]   syy;
      logic [SUM_W-1:0]   sxz;
      logic [SUM_W-1:0]   syz;
      logic [LIN_W-1:0]   sx;
      logic [LIN_W-1:0]   sy;
      logic [LIN_W-1:0]   sz;
   } glspf_sums_type;

   typedef struct packed {
      logic             done;
      logic             status;
      logic [OUT_W-1:0] slope_x;
      logic [OUT_W-1:0] slope_y;
      logic [OUT_W-1:0] offset;
   } glspf_result_type;

   localparam logic [2:0] OP_END  = 3'd0;
   localparam logic [2:0] OP_MUL  = 3'd1;
   localparam logic [2:0] OP_SUB  = 3'd2;
   localparam logic [2:0] OP_CHKZ = 3'd3;
   localparam logic [2:0] OP_DIV  = 3'd4;

   typedef struct packed {
      logic [2:0]         op;
      logic [RADDR_W-1:0] dst;
      logic [RADDR_W-1:0] src_a;
      logic [RADDR_W-1:0] src_b;
   } glspf_uop_type;

   // register file map
   localparam logic [RADDR_W-1:0] R_N   = 5'd0;
   localparam logic [RADDR_W-1:0] R_SXX = 5'd1;
   localparam logic [RADDR_W-1:0] R_SXY = 5'd2;
   localparam logic [RADDR_W-1:0] R_SYY = 5'd3;
   localparam logic [RADDR_W-1:0] R_SXZ = 5'd4;
   localparam logic [RADDR_W-1:0] R_SYZ = 5'd5;
   localparam logic [RADDR_W-1:0] R_WX  = 5'd6;
   localparam logic [RADDR_W-1:0] R_WY  = 5'd7;
   localparam logic [RADDR_W-1:0] R_WZ  = 5'd8;
   localparam logic [RADDR_W-1:0] R_K16 = 5'd9;
   localparam logic [RADDR_W-1:0] R_T0  = 5'd10;
   localparam logic [RADDR_W-1:0] R_T1  = 5'd11;
   localparam logic [RADDR_W-1:0] R_CXX = 5'd12;
   localparam logic [RADDR_W-1:0] R_CYY = 5'd13;
   localparam logic [RADDR_W-1:0] R_CXY = 5'd14;
   localparam logic [RADDR_W-1:0] R_CXZ = 5'd15;
   localparam logic [RADDR_W-1:0] R_CYZ = 5'd16;
   localparam logic [RADDR_W-1:0] R_DET = 5'd17;
   localparam logic [RADDR_W-1:0] R_NA  = 5'd18;
   localparam logic [RADDR_W-1:0] R_NB  = 5'd19;
   localparam logic [RADDR_W-1:0] R_NC  = 5'd20;
   localparam int                 REGS  = 21;

   // coefficient slots for divide results
   localparam logic [RADDR_W-1:0] C_SLOPE_X = 5'd0;
   localparam logic [RADDR_W-1:0] C_SLOPE_Y = 5'd1;
   localparam logic [RADDR_W-1:0] C_OFFSET  = 5'd2;

   function automatic glspf_uop_type glspf_prog(input logic [PC_W-1:0] pc);
      glspf_uop_type u;
      case (pc)
         6'd0:  u = '{OP_MUL, R_T0, R_N, R_SXX};
         6'd1:  u = '{OP_MUL, R_T1, R_WX, R_WX};
         6'd2:  u = '{OP_SUB, R_CXX, R_T0, R_T1};
         6'd3:  u = '{OP_MUL, R_T0, R_N, R_SYY};
         6'd4:  u = '{OP_MUL, R_T1, R_WY, R_WY};
         6'd5:  u = '{OP_SUB, R_CYY, R_T0, R_T1};
         6'd6:  u = '{OP_MUL, R_T0, R_N, R_SXY};
         6'd7:  u = '{OP_MUL, R_T1, R_WX, R_WY};
         6'd8:  u = '{OP_SUB, R_CXY, R_T0, R_T1};
         6'd9:  u = '{OP_MUL, R_T0, R_N, R_SXZ};
         6'd10: u = '{OP_MUL, R_T1, R_WX, R_WZ};
         6'd11: u = '{OP_SUB, R_CXZ, R_T0, R_T1};
         6'd12: u = '{OP_MUL, R_T0, R_N, R_SYZ};
         6'd13: u = '{OP_MUL, R_T1, R_WY, R_WZ};
         6'd14: u = '{OP_SUB, R_CYZ, R_T0, R_T1};
         6'd15: u = '{OP_MUL, R_T0, R_CXX, R_CYY};
         6'd16: u = '{OP_MUL, R_T1, R_CXY, R_CXY};
         6'd17: u = '{OP_SUB, R_DET, R_T0, R_T1};
         6'd18: u = '{OP_CHKZ, R_DET, R_DET, R_DET};
         6'd19: u = '{OP_MUL, R_T0, R_CXZ, R_CYY};
         6'd20: u = '{OP_MUL, R_T1, R_CYZ, R_CXY};
         6'd21: u = '{OP_SUB, R_NA, R_T0, R_T1};
         6'd22: u = '{OP_MUL, R_T0, R_CYZ, R_CXX};
         6'd23: u = '{OP_MUL, R_T1, R_CXZ, R_CXY};
         6'd24: u = '{OP_SUB, R_NB, R_T0, R_T1};
         6'd25: u = '{OP_MUL, R_T0, R_WZ, R_DET};
         6'd26: u = '{OP_MUL, R_T1, R_NA, R_WX};
         6'd27: u = '{OP_SUB, R_T0, R_T0, R_T1};
         6'd28: u = '{OP_MUL, R_T1, R_NB, R_WY};
         6'd29: u = '{OP_SUB, R_NC, R_T0, R_T1};
         6'd30: u = '{OP_MUL, R_T0, R_NA, R_K16};
         6'd31: u = '{OP_DIV, C_SLOPE_X, R_T0, R_DET};
         6'd32: u = '{OP_MUL, R_T0, R_NB, R_K16};
         6'd33: u = '{OP_DIV, C_SLOPE_Y, R_T0, R_DET};
         6'd34: u = '{OP_MUL, R_T1, R_N, R_DET};
         6'd35: u = '{OP_DIV, C_OFFSET, R_NC, R_T1};
         default: u = '{OP_END, R_N, R_N, R_N};
      endcase
      return u;
   endfunction

endpackage

@@ hdl/glspf_solver.sv @@
// microcoded 256-bit solver for the 3x3 normal equations
// depends on glspf_pkg; one shared adder serves shift-add multiply, subtract and divide
module glspf_solver (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  glspf_pkg::glspf_sums_type   sums,
   output glspf_pkg::glspf_result_type res
);
   import glspf_pkg::*;

   localparam int CNT_W = $clog2(WIDE_W);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LOAD  = 4'd1;
   localparam logic [3:0] S_FETCH = 4'd2;
   localparam logic [3:0] S_RDA   = 4'd3;
   localparam logic [3:0] S_RDB   = 4'd4;
   localparam logic [3:0] S_EXEC  = 4'd5;
   localparam logic [3:0] S_WRITE = 4'd6;
   localparam logic [3:0] S_ABSA  = 4'd7;
   localparam logic [3:0] S_ABSB  = 4'd8;
   localparam logic [3:0] S_DIV   = 4'd9;
   localparam logic [3:0] S_SAT   = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;

   localparam logic [RADDR_W-1:0] LOAD_LAST = R_K16;
   localparam logic [CNT_W-1:0]   CNT_LAST  = CNT_W'(WIDE_W - 1);

   logic [3:0]         state_ff, state_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [RADDR_W-1:0] load_ff, load_in;
   logic [WIDE_W-1:0]  a_ff, a_in, b_ff, b_in, acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic               status_ff, status_in;
   logic [OUT_W-1:0]   slope_x_ff, slope_x_in, slope_y_ff, slope_y_in;
   logic [OUT_W-1:0]   offset_ff, offset_in;

   logic [WIDE_W-1:0]  mem [0:REGS-1];
   logic               we;
   logic [RADDR_W-1:0] wr_addr, rd_addr;
   logic [WIDE_W-1:0]  wr_data, rd_data_ff, load_val;

   logic [WIDE_W-1:0]  add_x, add_y;
   logic               add_inv;
   logic [WIDE_W:0]    add_res;
   logic [WIDE_W-1:0]  remsh;
   logic [OUT_W-1:0]   sat_q;
   logic               q_big;
   glspf_uop_type      uop;

   assign uop = glspf_prog(pc_ff);

   // shared adder: x + y, or x - y when inverted
   assign add_res = {1'b0, add_x} + {1'b0, add_y ^ {WIDE_W{add_inv}}}
                    + {{WIDE_W{1'b0}}, add_inv};

   assign remsh = {acc_ff[WIDE_W-2:0], a_ff[WIDE_W-1]};

   always_comb begin
      case (load_ff)
         R_N:     load_val = {{(WIDE_W-COUNT_W){1'b0}}, sums.kept};
         R_SXX:   load_val = {{(WIDE_W-SUM_W){sums.sxx[SUM_W-1]}}, sums.sxx};
         R_SXY:   load_val = {{(WIDE_W-SUM_W){sums.sxy[SUM_W-1]}}, sums.sxy};
         R_SYY:   load_val = {{(WIDE_W-SUM_W){sums.syy[SUM_W-1]}}, sums.syy};
         R_SXZ:   load_val = {{(WIDE_W-SUM_W){sums.sxz[SUM_W-1]}}, sums.sxz};
         R_SYZ:   load_val = {{(WIDE_W-SUM_W){sums.syz[SUM_W-1]}}, sums.syz};
         R_WX:    load_val = {{(WIDE_W-LIN_W){sums.sx[LIN_W-1]}}, sums.sx};
         R_WY:    load_val = {{(WIDE_W-LIN_W){sums.sy[LIN_W-1]}}, sums.sy};
         R_WZ:    load_val = {{(WIDE_W-LIN_W){sums.sz[LIN_W-1]}}, sums.sz};
         R_K16:   load_val = WIDE_W'(65536);
         default: load_val = '0;
      endcase
   end

   // truncated quotient magnitude in a_ff, saturate to signed 32 bits
   always_comb begin
      q_big = |a_ff[WIDE_W-1:OUT_W];
      if (neg_ff) begin
         if (q_big || a_ff[OUT_W-1:0] > 32'h8000_0000) sat_q = 32'h8000_0000;
         else sat_q = 32'd0 - a_ff[OUT_W-1:0];
      end else begin
         if (q_big || a_ff[OUT_W-1]) sat_q = 32'h7fff_ffff;
         else sat_q = a_ff[OUT_W-1:0];
      end
   end

   always_comb begin
      state_in   = state_ff;
      pc_in      = pc_ff;
      cnt_in     = cnt_ff;
      load_in    = load_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      acc_in     = acc_ff;
      neg_in     = neg_ff;
      status_in  = status_ff;
      slope_x_in = slope_x_ff;
      slope_y_in = slope_y_ff;
      offset_in  = offset_ff;
      we         = 1'b0;
      wr_addr    = uop.dst;
      wr_data    = acc_ff;
      rd_addr    = uop.src_a;
      add_x      = acc_ff;
      add_y      = '0;
      add_inv    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               load_in    = '0;
               status_in  = 1'b0;
               slope_x_in = '0;
               slope_y_in = '0;
               offset_in  = '0;
               state_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            we      = 1'b1;
            wr_addr = load_ff;
            wr_data = load_val;
            load_in = load_ff + 1'b1;
            if (load_ff == LOAD_LAST) begin
               pc_in    = '0;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            if (uop.op == OP_END) state_in = S_DONE;
            else state_in = S_RDA;
         end
         S_RDA: begin
            a_in     = rd_data_ff;
            rd_addr  = uop.src_b;
            state_in = S_RDB;
         end
         S_RDB: begin
            b_in   = rd_data_ff;
            acc_in = '0;
            cnt_in = '0;
            if (uop.op == OP_DIV) state_in = S_ABSA;
            else state_in = S_EXEC;
         end
         S_EXEC: begin
            case (uop.op)
               OP_MUL: begin
                  add_y  = b_ff[0] ? a_ff : '0;
                  acc_in = add_res[WIDE_W-1:0];
                  a_in   = {a_ff[WIDE_W-2:0], 1'b0};
                  b_in   = {1'b0, b_ff[WIDE_W-1:1]};
                  cnt_in = cnt_ff + 1'b1;
                  if (cnt_ff == CNT_LAST) state_in = S_WRITE;
               end
               OP_SUB: begin
                  add_x    = a_ff;
                  add_y    = b_ff;
                  add_inv  = 1'b1;
                  acc_in   = add_res[WIDE_W-1:0];
                  state_in = S_WRITE;
               end
               OP_CHKZ: begin
                  if (a_ff == '0) begin
                     status_in = 1'b1;
                     state_in  = S_DONE;
                  end else begin
                     pc_in    = pc_ff + 1'b1;
                     state_in = S_FETCH;
                  end
               end
               default: state_in = S_DONE;
            endcase
         end
         S_WRITE: begin
            we       = 1'b1;
            pc_in    = pc_ff + 1'b1;
            state_in = S_FETCH;
         end
         S_ABSA: begin
            neg_in  = a_ff[WIDE_W-1] ^ b_ff[WIDE_W-1];
            add_x   = '0;
            add_y   = a_ff;
            add_inv = 1'b1;
            if (a_ff[WIDE_W-1]) a_in = add_res[WIDE_W-1:0];
            state_in = S_ABSB;
         end
         S_ABSB: begin
            add_x   = '0;
            add_y   = b_ff;
            add_inv = 1'b1;
            if (b_ff[WIDE_W-1]) b_in = add_res[WIDE_W-1:0];
            acc_in   = '0;
            cnt_in   = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            // restoring step: carry out set means the shifted remainder covers the divisor
            add_x   = remsh;
            add_y   = b_ff;
            add_inv = 1'b1;
            acc_in  = add_res[WIDE_W] ? add_res[WIDE_W-1:0] : remsh;
            a_in    = {a_ff[WIDE_W-2:0], add_res[WIDE_W]};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) state_in = S_SAT;
         end
         S_SAT: begin
            case (uop.dst)
               C_SLOPE_X: slope_x_in = sat_q;
               C_SLOPE_Y: slope_y_in = sat_q;
               default:   offset_in  = sat_q;
            endcase
            pc_in    = pc_ff + 1'b1;
            state_in = S_FETCH;
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pc_ff      <= pc_in;
      cnt_ff     <= cnt_in;
      load_ff    <= load_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      acc_ff     <= acc_in;
      neg_ff     <= neg_in;
      status_ff  <= status_in;
      slope_x_ff <= slope_x_in;
      slope_y_ff <= slope_y_in;
      offset_ff  <= offset_in;
   end

   always_ff @(posedge clock) begin
      if (we) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   assign res.done    = (state_ff == S_DONE);
   assign res.status  = status_ff;
   assign res.slope_x = slope_x_ff;
   assign res.slope_y = slope_y_ff;
   assign res.offset  = offset_ff;

endmodule

@@ hdl/gated_least_squares_plane_fit.sv @@
// Plane fit z = a*x + b*y + c over a gated point cloud. Each point word is
// taken in its accepting cycle, then ten products come from one shared 25x25
// multiplier (four squares for the two gate distances, the squared range limit
// and the five cross products, one per cycle) and a last step adds the final
// product. A word marked last with at least three kept points then runs the
// microcoded solver (it ends early when the system is singular), whose multiply
// and divide are bit-serial over 256 bits on one shared adder. The input is
// stalled while a point, a solve or the hand-over of a result is in progress;
// the result sits in an output register, so points of the next cloud are taken
// while it waits. The range limit may be written whenever the block is idle.
// depends on glspf_pkg, glspf_solver and gated_least_squares_plane_fit_defines.svh
`include "gated_least_squares_plane_fit_defines.svh"
module gated_least_squares_plane_fit #(
   parameter int MAX_POINTS  = glspf_pkg::MAX_POINTS_DEF,
   parameter int COORD_WIDTH = glspf_pkg::COORD_WIDTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [glspf_pkg::PORT_W-1:0] req_sensor_x,
   input  logic signed [glspf_pkg::PORT_W-1:0] req_sensor_y,
   input  logic signed [glspf_pkg::PORT_W-1:0] req_base_x,
   input  logic signed [glspf_pkg::PORT_W-1:0] req_base_y,
   input  logic signed [glspf_pkg::PORT_W-1:0] req_base_z,
   input  logic                              req_last_point,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [glspf_pkg::OUT_W-1:0]  rsp_slope_x,
   output logic signed [glspf_pkg::OUT_W-1:0]  rsp_slope_y,
   output logic signed [glspf_pkg::OUT_W-1:0]  rsp_offset,
   output logic [glspf_pkg::COUNT_W-1:0]     rsp_points_used,
   output logic                              rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [glspf_pkg::RANGE_W-1:0]     csr_range_limit
);
   import glspf_pkg::*;

   localparam int MAG_W  = PORT_W + 1;
   localparam int PROD_W = 2 * MAG_W;
   localparam int SHIFT  = PORT_W - COORD_WIDTH;

   localparam logic [2:0] T_IDLE  = 3'd0;
   localparam logic [2:0] T_POINT = 3'd1;
   localparam logic [2:0] T_FIN   = 3'd2;
   localparam logic [2:0] T_SOLVE = 3'd3;
   localparam logic [2:0] T_EMIT  = 3'd4;

   // each step issues one product and consumes the one before it
   localparam logic [3:0] STEP_SX2 = 4'd0;
   localparam logic [3:0] STEP_SY2 = 4'd1;
   localparam logic [3:0] STEP_AX2 = 4'd2;
   localparam logic [3:0] STEP_AY2 = 4'd3;
   localparam logic [3:0] STEP_MR2 = 4'd4;
   localparam logic [3:0] STEP_XX  = 4'd5;
   localparam logic [3:0] STEP_XY  = 4'd6;
   localparam logic [3:0] STEP_YY  = 4'd7;
   localparam logic [3:0] STEP_XZ  = 4'd8;
   localparam logic [3:0] STEP_YZ  = 4'd9;
   localparam logic [3:0] STEP_END = 4'd10;

   function automatic logic signed [PORT_W-1:0] coord(input logic signed [PORT_W-1:0] v);
      return (v <<< SHIFT) >>> SHIFT;
   endfunction

   function automatic logic signed [MAG_W-1:0] mag(input logic signed [PORT_W-1:0] v);
      logic signed [MAG_W-1:0] w;
      w = {v[PORT_W-1], v};
      return v[PORT_W-1] ? -w : w;
   endfunction

   logic [2:0]               state_ff, state_in;
   logic [3:0]               step_ff, step_in;
   logic [RANGE_W-1:0]       range_ff, range_in;
   logic signed [MAG_W-1:0]  sx_ff, sx_in, sy_ff, sy_in, ax_ff, ax_in, ay_ff, ay_in;
   logic signed [PORT_W-1:0] bx_ff, bx_in, by_ff, by_in, bz_ff, bz_in;
   logic                     last_ff, last_in;
   logic signed [PROD_W-1:0] prod_ff, mul_out;
   logic signed [MAG_W-1:0]  mul_a, mul_b;
   logic [LIN_W-1:0]         near_ff, near_in, far_ff, far_in;
   logic                     keep_ff, keep_in;
   logic                     short_ff, short_in;
   logic [SUM_W-1:0]         sxx_ff, sxx_in, sxy_ff, sxy_in, syy_ff, syy_in;
   logic [SUM_W-1:0]         sxz_ff, sxz_in, syz_ff, syz_in;
   logic [LIN_W-1:0]         wx_ff, wx_in, wy_ff, wy_in, wz_ff, wz_in;
   logic [COUNT_W-1:0]       kept_ff, kept_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]         slope_x_ff, slope_x_in, slope_y_ff, slope_y_in;
   logic [OUT_W-1:0]         offset_ff, offset_in;
   logic [COUNT_W-1:0]       used_ff, used_in;
   logic                     status_ff, status_in;
   logic [SUM_W-1:0]         prod_ext;
   logic                     out_free;
   logic                     solve_start;
   glspf_sums_type           sums;
   glspf_result_type         res;

   glspf_solver u_solver (
      .clock (clock),
      .reset (reset),
      .start (solve_start),
      .sums  (sums),
      .res   (res)
   );

   assign sums = '{kept: kept_ff, sxx: sxx_ff, sxy: sxy_ff, syy: syy_ff, sxz: sxz_ff,
                   syz: syz_ff, sx: wx_ff, sy: wy_ff, sz: wz_ff};

   assign req_stall   = (state_ff != T_IDLE);
   assign csr_ready   = 1'b1;
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign solve_start = (state_ff == T_FIN) && (kept_ff >= MIN_POINTS);
   assign prod_ext    = {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign mul_out     = mul_a * mul_b;

   always_comb begin
      case (step_ff)
         STEP_SX2: begin mul_a = sx_ff; mul_b = sx_ff; end
         STEP_SY2: begin mul_a = sy_ff; mul_b = sy_ff; end
         STEP_AX2: begin mul_a = ax_ff; mul_b = ax_ff; end
         STEP_AY2: begin mul_a = ay_ff; mul_b = ay_ff; end
         STEP_MR2: begin
            mul_a = $signed({{(MAG_W-RANGE_W){1'b0}}, range_ff});
            mul_b = $signed({{(MAG_W-RANGE_W){1'b0}}, range_ff});
         end
         STEP_XX: begin mul_a = {bx_ff[PORT_W-1], bx_ff}; mul_b = {bx_ff[PORT_W-1], bx_ff}; end
         STEP_XY: begin mul_a = {bx_ff[PORT_W-1], bx_ff}; mul_b = {by_ff[PORT_W-1], by_ff}; end
         STEP_YY: begin mul_a = {by_ff[PORT_W-1], by_ff}; mul_b = {by_ff[PORT_W-1], by_ff}; end
         STEP_XZ: begin mul_a = {bx_ff[PORT_W-1], bx_ff}; mul_b = {bz_ff[PORT_W-1], bz_ff}; end
         STEP_YZ: begin mul_a = {by_ff[PORT_W-1], by_ff}; mul_b = {bz_ff[PORT_W-1], bz_ff}; end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      range_in     = range_ff;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      ax_in        = ax_ff;
      ay_in        = ay_ff;
      bx_in        = bx_ff;
      by_in        = by_ff;
      bz_in        = bz_ff;
      last_in      = last_ff;
      near_in      = near_ff;
      far_in       = far_ff;
      keep_in      = keep_ff;
      short_in     = short_ff;
      sxx_in       = sxx_ff;
      sxy_in       = sxy_ff;
      syy_in       = syy_ff;
      sxz_in       = sxz_ff;
      syz_in       = syz_ff;
      wx_in        = wx_ff;
      wy_in        = wy_ff;
      wz_in        = wz_ff;
      kept_in      = kept_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      slope_x_in   = slope_x_ff;
      slope_y_in   = slope_y_ff;
      offset_in    = offset_ff;
      used_in      = used_ff;
      status_in    = status_ff;
      if (csr_valid) range_in = csr_range_limit;
      case (state_ff)
         T_IDLE: begin
            if (req_valid) begin
               sx_in    = mag(coord(req_sensor_x));
               sy_in    = mag(coord(req_sensor_y));
               ax_in    = mag(coord(req_base_x));
               ay_in    = mag(coord(req_base_y));
               bx_in    = coord(req_base_x);
               by_in    = coord(req_base_y);
               bz_in    = coord(req_base_z);
               last_in  = req_last_point;
               step_in  = STEP_SX2;
               state_in = T_POINT;
            end
         end
         T_POINT: begin
            step_in = step_ff + 1'b1;
            case (step_ff)
               STEP_SY2: near_in = prod_ff[LIN_W-1:0];
               STEP_AX2: near_in = near_ff + prod_ff[LIN_W-1:0];
               STEP_AY2: far_in  = prod_ff[LIN_W-1:0];
               STEP_MR2: far_in  = far_ff + prod_ff[LIN_W-1:0];
               STEP_XX: keep_in = (near_ff >= NEAR_SQ) && (far_ff <= prod_ff[LIN_W-1:0])
                                  && (kept_ff < COUNT_W'(MAX_POINTS));
               STEP_XY: if (keep_ff) sxx_in = sxx_ff + prod_ext;
               STEP_YY: if (keep_ff) sxy_in = sxy_ff + prod_ext;
               STEP_XZ: if (keep_ff) syy_in = syy_ff + prod_ext;
               STEP_YZ: if (keep_ff) sxz_in = sxz_ff + prod_ext;
               STEP_END: begin
                  if (keep_ff) begin
                     syz_in  = syz_ff + prod_ext;
                     wx_in   = wx_ff + {{(LIN_W-PORT_W){bx_ff[PORT_W-1]}}, bx_ff};
                     wy_in   = wy_ff + {{(LIN_W-PORT_W){by_ff[PORT_W-1]}}, by_ff};
                     wz_in   = wz_ff + {{(LIN_W-PORT_W){bz_ff[PORT_W-1]}}, bz_ff};
                     kept_in = kept_ff + 1'b1;
                  end
                  state_in = last_ff ? T_FIN : T_IDLE;
               end
               default: ;
            endcase
         end
         T_FIN: begin
            short_in = (kept_ff < MIN_POINTS);
            state_in = (kept_ff < MIN_POINTS) ? T_EMIT : T_SOLVE;
         end
         T_SOLVE: begin
            if (res.done) state_in = T_EMIT;
         end
         T_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               slope_x_in   = short_ff ? '0 : res.slope_x;
               slope_y_in   = short_ff ? '0 : res.slope_y;
               offset_in    = short_ff ? '0 : res.offset;
               status_in    = short_ff ? 1'b1 : res.status;
               used_in      = kept_ff;
               sxx_in       = '0;
               sxy_in       = '0;
               syy_in       = '0;
               sxz_in       = '0;
               syz_in       = '0;
               wx_in        = '0;
               wy_in        = '0;
               wz_in        = '0;
               kept_in      = '0;
               state_in     = T_IDLE;
            end
         end
         default: state_in = T_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_IDLE;
         rsp_valid_ff <= 1'b0;
         range_ff     <= RANGE_LIMIT_RESET;
         sxx_ff       <= '0;
         sxy_ff       <= '0;
         syy_ff       <= '0;
         sxz_ff       <= '0;
         syz_ff       <= '0;
         wx_ff        <= '0;
         wy_ff        <= '0;
         wz_ff        <= '0;
         kept_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         range_ff     <= range_in;
         sxx_ff       <= sxx_in;
         sxy_ff       <= sxy_in;
         syy_ff       <= syy_in;
         sxz_ff       <= sxz_in;
         syz_ff       <= syz_in;
         wx_ff        <= wx_in;
         wy_ff        <= wy_in;
         wz_ff        <= wz_in;
         kept_ff      <= kept_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      sx_ff      <= sx_in;
      sy_ff      <= sy_in;
      ax_ff      <= ax_in;
      ay_ff      <= ay_in;
      bx_ff      <= bx_in;
      by_ff      <= by_in;
      bz_ff      <= bz_in;
      last_ff    <= last_in;
      prod_ff    <= mul_out;
      near_ff    <= near_in;
      far_ff     <= far_in;
      keep_ff    <= keep_in;
      short_ff   <= short_in;
      slope_x_ff <= slope_x_in;
      slope_y_ff <= slope_y_in;
      offset_ff  <= offset_in;
      used_ff    <= used_in;
      status_ff  <= status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_slope_x     = slope_x_ff;
   assign rsp_slope_y     = slope_y_ff;
   assign rsp_offset      = offset_ff;
   assign rsp_points_used = used_ff;
   assign rsp_status      = status_ff;

   `GLSPF_ASSERT_IMP(a_solve_done_in_solve, clock, reset, res.done, state_ff == T_SOLVE)
   `GLSPF_ASSERT_IMP(a_fail_gives_zeros, clock, reset, rsp_valid && rsp_status,
      rsp_slope_x == 0 && rsp_slope_y == 0 && rsp_offset == 0)
   `GLSPF_ASSERT_IMP(a_solved_has_points, clock, reset, rsp_valid && !rsp_status,
      rsp_points_used >= MIN_POINTS)
   `GLSPF_ASSERT_IMP(a_kept_capped, clock, reset, 1'b1, kept_ff <= COUNT_W'(MAX_POINTS))
   `GLSPF_ASSERT_NXT(a_emit_clears_sums, clock, reset, state_ff == T_EMIT && out_free,
      kept_ff == 0 && rsp_valid)

endmodule
